[rtl/core/lmph_pkg.sv]
// Shared constants for the level meter with peak hold: register codes,
// reset values, the log2 fraction table and the dB scaling constant.
// No dependencies.
package lmph_pkg;

	// configuration register indices
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_DECAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DECAY  = 2'd2;

	localparam int unsigned HOLD_W   = 8;
	localparam int unsigned FACTOR_W = 16;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [HOLD_W-1:0]   HOLD_FRAMES_RST = 8'd45;
	localparam logic [FACTOR_W-1:0] LEVEL_DECAY_RST = 16'd58982;
	localparam logic [FACTOR_W-1:0] HOLD_DECAY_RST  = 16'd62259;

	// fraction below the leading one, table index and interpolation weight
	localparam int unsigned FRAC_W    = 20;
	localparam int unsigned TIDX_W    = 4;
	localparam int unsigned TREM_W    = 16;
	localparam int unsigned TAB_W     = 17;
	localparam int unsigned TAB_ADR_W = 5;
	localparam int unsigned TAB_N     = 17;

	typedef logic [TAB_W-1:0] tab_word_t;

	// round(65536 * log2(1 + i/16))
	localparam tab_word_t LOG2_TAB [TAB_N] = '{
		17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
		17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
		17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
	};

	// 20*log10(2) in Q16
	localparam int unsigned DBQ_W = 19;
	localparam logic [DBQ_W-1:0] DB_PER_OCTAVE_Q16 = 19'd394566;

endpackage

[rtl/core/level_meter_peak_hold.sv]
// Level meter with fast attack and peak hold; uses lmph_pkg.
// An accepted amplitude passes the input, normalise, log2, dB and level registers,
// then the meter and peak registers that drive the result. Throughput: one amplitude
// per cycle unless a stalled result backs up the pipeline; set by the state update stage,
// where the meter and peak recurrences each close through one 16-bit multiply.
// Reset (arst_n low): meter, peak and hold count cleared, pipeline emptied, configuration back to its defaults.
module level_meter_peak_hold #(
	parameter int unsigned FLOOR_DB        = 60,
	parameter int unsigned INPUT_BITS      = 16,
	parameter int unsigned LEVEL_FRAC_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// amplitude transactions
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic [INPUT_BITS-1:0]                 amplitude,
	// result transactions
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [LEVEL_FRAC_BITS:0]              meter_level,
	output logic [LEVEL_FRAC_BITS:0]              peak_level,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lmph_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lmph_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import lmph_pkg::*;

	// ---------------------------------------------------------------------
	// Derived widths
	// ---------------------------------------------------------------------
	// msb position of the amplitude
	localparam int unsigned PB_W   = $clog2(INPUT_BITS);
	// log2 in Q16, wide enough to hold INPUT_BITS << 16
	localparam int unsigned LQ_W   = $clog2(INPUT_BITS + 1) + 16;
	// dB scaling product and its value after the Q shift
	localparam int unsigned MUL_W  = LQ_W + DBQ_W;
	localparam int unsigned SH_DB  = 32 - LEVEL_FRAC_BITS;
	localparam int unsigned SC_W   = MUL_W - SH_DB;
	// exact floor division by FLOOR_DB: x * ceil(2^(SC_W+l) / D) >> (SC_W+l)
	localparam int unsigned DIV_L  = $clog2(FLOOR_DB);
	localparam int unsigned DIV_SH = SC_W + DIV_L;
	localparam int unsigned RCP_W  = SC_W + 1;
	localparam longint unsigned RCP_VAL =
		((64'd1 << DIV_SH) + FLOOR_DB - 1) / FLOOR_DB;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_VAL);
	localparam int unsigned DP_W   = SC_W + RCP_W;
	localparam int unsigned DROP_W = DP_W - DIV_SH;
	// output level, unsigned Q1.LEVEL_FRAC_BITS, so full scale fits
	localparam int unsigned OUT_W  = LEVEL_FRAC_BITS + 1;
	localparam int unsigned CMP_W  = (DROP_W > OUT_W) ? DROP_W : OUT_W;

	localparam logic [LQ_W-1:0]  LOG_REF    = LQ_W'(INPUT_BITS - 1) << 16;
	localparam logic [OUT_W-1:0] FULL_LEVEL = OUT_W'(1) << LEVEL_FRAC_BITS;

	// ---------------------------------------------------------------------
	// Configuration registers; writes are always taken
	// ---------------------------------------------------------------------
	logic [HOLD_W-1:0]   hold_frames_q;
	logic [FACTOR_W-1:0] level_decay_q;
	logic [FACTOR_W-1:0] hold_decay_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_frames_q <= HOLD_FRAMES_RST;
			level_decay_q <= LEVEL_DECAY_RST;
			hold_decay_q  <= HOLD_DECAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HOLD_FRAMES: hold_frames_q <= cfg_data[HOLD_W-1:0];
				CFG_LEVEL_DECAY: level_decay_q <= cfg_data[FACTOR_W-1:0];
				CFG_HOLD_DECAY:  hold_decay_q  <= cfg_data[FACTOR_W-1:0];
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Flow control
	// Each stage loads when it is empty or its contents move on, so bubbles
	// close up and amplitudes keep being taken while a result waits, until every stage is full.
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic res_v_q;
	logic rdy_res, rdy_s5, rdy_s4, rdy_s3, rdy_s2, rdy_s1;

	assign rdy_res = !res_v_q || !result_stall;
	assign rdy_s5  = !v_s5 || rdy_res;
	assign rdy_s4  = !v_s4 || rdy_s5;
	assign rdy_s3  = !v_s3 || rdy_s4;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;

	assign item_stall   = !rdy_s1;
	assign result_valid = res_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1    <= item_valid;
			if (rdy_s2)  v_s2    <= v_s1;
			if (rdy_s3)  v_s3    <= v_s2;
			if (rdy_s4)  v_s4    <= v_s3;
			if (rdy_s5)  v_s5    <= v_s4;
			if (rdy_res) res_v_q <= v_s5;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------------
	logic [INPUT_BITS-1:0] amp_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) amp_s1 <= amplitude;
	end

	// ---------------------------------------------------------------------
	// Stage 2: leading-one detect and normalise.
	// The bits under the leading one become a 20-bit fraction; with more
	// than 20 of them the rest is truncated, with fewer it is zero padded.
	// ---------------------------------------------------------------------
	logic [PB_W-1:0]       msb_pos;
	logic [PB_W-1:0]       norm_sh;
	logic [INPUT_BITS-1:0] amp_norm;
	logic [INPUT_BITS+FRAC_W-2:0] frac_ext;

	always_comb begin
		msb_pos = '0;
		for (int i = 0; i < INPUT_BITS; i++) begin
			if (amp_s1[i]) msb_pos = PB_W'(i);
		end
	end

	assign norm_sh  = PB_W'(INPUT_BITS - 1) - msb_pos;
	assign amp_norm = amp_s1 << norm_sh;
	assign frac_ext = {amp_norm[INPUT_BITS-2:0], {FRAC_W{1'b0}}};

	logic [PB_W-1:0]   pos_s2;
	logic [FRAC_W-1:0] frac_s2;
	logic              zero_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			pos_s2  <= msb_pos;
			frac_s2 <= frac_ext[INPUT_BITS+FRAC_W-2 -: FRAC_W];
			zero_s2 <= (amp_s1 == '0);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: table interpolation to log2 in Q16, distance below full scale
	// ---------------------------------------------------------------------
	logic [TAB_ADR_W-1:0]     tab_lo;
	logic [TAB_ADR_W-1:0]     tab_hi;
	logic [TREM_W-1:0]        tab_rem;
	tab_word_t                tab_diff;
	logic [TAB_W+TREM_W-1:0]  interp;
	tab_word_t                log_frac;
	logic [LQ_W-1:0]          log_q;

	assign tab_lo   = TAB_ADR_W'(frac_s2[FRAC_W-1 -: TIDX_W]);
	assign tab_hi   = tab_lo + TAB_ADR_W'(1);
	assign tab_rem  = frac_s2[TREM_W-1:0];
	assign tab_diff = LOG2_TAB[tab_hi] - LOG2_TAB[tab_lo];
	assign interp   = (TAB_W+TREM_W)'(tab_diff) * (TAB_W+TREM_W)'(tab_rem);
	assign log_frac = LOG2_TAB[tab_lo] + TAB_W'(interp >> TREM_W);
	assign log_q    = (LQ_W'(pos_s2) << 16) + LQ_W'(log_frac);

	logic [LQ_W-1:0] delta_s3;
	logic            full_s3;
	logic            zero_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			delta_s3 <= LOG_REF - log_q;
			full_s3  <= (log_q >= LOG_REF);
			zero_s3  <= zero_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: scale octaves to dB, keep LEVEL_FRAC_BITS fraction bits
	// ---------------------------------------------------------------------
	logic [MUL_W-1:0] db_prod;

	assign db_prod = MUL_W'(delta_s3) * MUL_W'(DB_PER_OCTAVE_Q16);

	logic [SC_W-1:0] scaled_s4;
	logic            full_s4;
	logic            zero_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			scaled_s4 <= db_prod[MUL_W-1:SH_DB];
			full_s4   <= full_s3;
			zero_s4   <= zero_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: divide by the floor through the reciprocal, clamp to range
	// ---------------------------------------------------------------------
	logic [DP_W-1:0]   div_prod;
	logic [DROP_W-1:0] drop;
	logic [OUT_W-1:0]  level_new;

	assign div_prod = DP_W'(scaled_s4) * DP_W'(RECIP);
	assign drop     = div_prod[DP_W-1:DIV_SH];

	always_comb begin
		if (zero_s4)
			level_new = '0;
		else if (full_s4)
			level_new = FULL_LEVEL;
		else if (CMP_W'(drop) >= CMP_W'(FULL_LEVEL))
			level_new = '0;
		else
			level_new = FULL_LEVEL - OUT_W'(drop);
	end

	logic [OUT_W-1:0] level_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) level_s5 <= level_new;
	end

	// ---------------------------------------------------------------------
	// Stage 6: ballistics. Fast attack on the meter, peak capture with a
	// saturating hold count; these registers also drive the result ports.
	// ---------------------------------------------------------------------
	logic [OUT_W-1:0]  meter_q;
	logic [OUT_W-1:0]  peak_q;
	logic [HOLD_W-1:0] hold_cnt_q;

	logic [OUT_W+FACTOR_W-1:0] meter_prod;
	logic [OUT_W+FACTOR_W-1:0] peak_prod;
	logic [HOLD_W-1:0]         hold_dec;

	assign meter_prod = (OUT_W+FACTOR_W)'(meter_q) * (OUT_W+FACTOR_W)'(level_decay_q);
	assign peak_prod  = (OUT_W+FACTOR_W)'(peak_q) * (OUT_W+FACTOR_W)'(hold_decay_q);
	// counter sticks at zero once run out
	assign hold_dec   = (hold_cnt_q != '0) ? hold_cnt_q - HOLD_W'(1) : '0;

	function automatic logic level_new_gt_meter(
		input logic [OUT_W-1:0] lvl,
		input logic [OUT_W-1:0] cur
	);
		return lvl > cur;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_q    <= '0;
			peak_q     <= '0;
			hold_cnt_q <= '0;
		end else if (v_s5 && rdy_res) begin
			if (level_new_gt_meter(level_s5, meter_q))
				meter_q <= level_s5;
			else
				meter_q <= meter_prod[OUT_W+FACTOR_W-1:FACTOR_W];

			if (level_s5 >= peak_q) begin
				peak_q     <= level_s5;
				hold_cnt_q <= hold_frames_q;
			end else begin
				hold_cnt_q <= hold_dec;
				// decays on the very step the count reaches zero
				if (hold_dec == '0) peak_q <= peak_prod[OUT_W+FACTOR_W-1:FACTOR_W];
			end
		end
	end

	assign meter_level = meter_q;
	assign peak_level  = peak_q;

endmodule

[rtl/core/lmph_chk.sv]
// Port-level checks for level_meter_peak_hold, bound to the top level.
// Depends on level_meter_peak_hold only through the bind below.
module lmph_chk #(
	parameter int unsigned LEVEL_FRAC_BITS = 12
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic [LEVEL_FRAC_BITS:0]   meter_level,
	input logic [LEVEL_FRAC_BITS:0]   peak_level
);
	localparam logic [LEVEL_FRAC_BITS:0] FULL = (LEVEL_FRAC_BITS+1)'(1) << LEVEL_FRAC_BITS;

	// input only backs up once every stage is full behind a stalled result
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("amplitude stalled while the result side was free");

	// a stalled result transaction holds its payload
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(meter_level) && $stable(peak_level)))
		else $error("stalled result changed");

	a_meter_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (meter_level <= FULL))
		else $error("meter level above full scale");

	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (peak_level <= FULL))
		else $error("peak level above full scale");

endmodule

bind level_meter_peak_hold lmph_chk #(
	.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
) u_lmph_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.meter_level  (meter_level),
	.peak_level   (peak_level)
);
